[rtl/pfba_pkg.sv]
// Shared constants and request codes for the page frame bitmap allocator.
// No dependencies.
package pfba_pkg;

  localparam int FRAMES_PER_WORD_DEF = 32;
  localparam int BITMAP_WORDS_DEF    = 4096;
  localparam int PAGE_SHIFT_DEF      = 12;

  // Width of a byte address as it travels on the streams.
  localparam int ADDR_W  = 29;
  localparam int TDATA_W = 32;
  localparam int REQ_W   = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_MARK  = 2'd2
  } req_t;

endpackage

[rtl/page_frame_bitmap_allocator.sv]
// Allocate: accept in ST_IDLE, scan the summary chunk by chunk in ST_SCAN (up to
// ceil(ceil(BITMAP_WORDS/FRAMES_PER_WORD)/FRAMES_PER_WORD) chunks, 4 at defaults), then
// ST_L1 and ST_L0 (skipped if all chunks are empty); ST_WB then registers the result.
// Free and mark requests go through ST_SREAD to ST_WB; unused request codes and frames
// beyond the bitmap skip the read. The shared priority encoder and the single read port
// of each bitmap level set the rate. Reset (synchronous) clears the state, m_tvalid and
// the top-level summary flops only; no clearing pass is run, so the block is ready in the
// first cycle after reset. Depends on pfba_pkg.
module page_frame_bitmap_allocator #(
  parameter int FRAMES_PER_WORD = pfba_pkg::FRAMES_PER_WORD_DEF, // power of two
  parameter int BITMAP_WORDS    = pfba_pkg::BITMAP_WORDS_DEF,
  parameter int PAGE_SHIFT      = pfba_pkg::PAGE_SHIFT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [pfba_pkg::TDATA_W-1:0] s_tdata,  // [28:0] frame_address, [31:29] zero
  input  logic [pfba_pkg::REQ_W-1:0]   s_tuser,  // [1:0] req_type
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [pfba_pkg::TDATA_W-1:0] m_tdata,  // [28:0] alloc_address, [31:29] zero
  output logic [0:0]                   m_tuser   // [0] out_of_memory
);
  import pfba_pkg::*;

  localparam int W   = FRAMES_PER_WORD;
  localparam int N   = BITMAP_WORDS;
  localparam int LW  = $clog2(W);
  localparam int AW0 = (N > 1) ? $clog2(N) : 1;
  localparam int N1  = (N + W - 1) / W;
  localparam int AW1 = (N1 > 1) ? $clog2(N1) : 1;
  localparam int NC  = (N1 + W - 1) / W;
  localparam int CW  = (NC > 1) ? $clog2(NC) : 1;
  localparam int FW  = ADDR_W - PAGE_SHIFT;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_L1    = 6'b000100,
    ST_L0    = 6'b001000,
    ST_SREAD = 6'b010000,
    ST_WB    = 6'b100000
  } state_t;

  state_t state, state_next;

  // Level 0 holds the frame bits, level 1 one bit per nonempty level 0 word,
  // and the flops in l2 one bit per nonempty level 1 word. An entry whose
  // summary bit is clear is treated as zero, so the memories need no clearing.
  logic [W-1:0]   mem0 [N];
  logic [W-1:0]   mem1 [N1];
  logic [N1-1:0]  l2;
  logic [W-1:0]   rd0, rd1;
  logic [AW0-1:0] rd0_addr;
  logic [AW1-1:0] rd1_addr;

  logic [CW-1:0]  chunk;
  logic [AW1-1:0] g_r;
  logic [LW-1:0]  j_r, b_r;
  logic [AW0-1:0] w_r;
  logic [W-1:0]   l1word_r, new0_r, new1_r;
  logic           write_r, is_free_r;

  // Shared lowest-set-bit unit.
  logic [W-1:0]   pe_in;
  logic [LW-1:0]  pe_idx;
  logic           pe_any;

  always_comb begin
    pe_any = |pe_in;
    pe_idx = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (pe_in[i]) pe_idx = LW'(i);
    end
  end

  // Input decode.
  logic [FW-1:0]  frame_in;
  logic [31:0]    w_in32;
  logic           in_range;
  logic [AW0-1:0] w_in;
  logic [AW1-1:0] g_in;
  logic [LW-1:0]  j_in, bit_in;
  logic           in_fire, out_free, wb_fire;
  logic [REQ_W-1:0] req_in;

  assign req_in   = s_tuser;
  assign frame_in = s_tdata[ADDR_W-1:PAGE_SHIFT];
  assign bit_in   = frame_in[LW-1:0];
  assign w_in32   = 32'(frame_in[FW-1:LW]);
  assign in_range = w_in32 < 32'(N);
  assign w_in     = w_in32[AW0-1:0];
  assign g_in     = w_in32[LW +: AW1];
  assign j_in     = w_in32[LW-1:0];

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign wb_fire  = (state == ST_WB) && out_free;

  // Summary scan and index assembly.
  logic [NC*W-1:0]     l2_pad;
  logic [CW+LW-1:0]    g_scan_full;
  logic [AW1+LW-1:0]   w_full;
  logic [AW1-1:0]      g_scan;
  logic [AW0-1:0]      w_l1;

  assign l2_pad      = (NC*W)'(l2);
  assign g_scan_full = {chunk, pe_idx};
  assign g_scan      = g_scan_full[AW1-1:0];
  assign w_full      = {g_r, pe_idx};
  assign w_l1        = w_full[AW0-1:0];

  // Read-modify-write values for free and mark requests and for allocation.
  logic [W-1:0] l1eff, l0eff, s_new0, s_new1, bit_mask;
  logic [W-1:0] a_new0, a_new1;

  always_comb begin
    l1eff    = l2[g_r] ? rd1 : '0;
    l0eff    = l1eff[j_r] ? rd0 : '0;
    bit_mask = W'(1) << b_r;
    s_new0   = is_free_r ? (l0eff | bit_mask) : (l0eff & ~bit_mask);
    s_new1   = l1eff;
    s_new1[j_r] = |s_new0;
    a_new0   = rd0 & ~(W'(1) << pe_idx);
    a_new1   = l1word_r;
    a_new1[j_r] = |a_new0;
  end

  always_comb begin
    pe_in    = '0;
    rd0_addr = w_r;
    rd1_addr = g_r;
    unique case (state)
      ST_IDLE: begin
        rd0_addr = w_in;
        rd1_addr = g_in;
      end
      ST_SCAN: begin
        pe_in    = l2_pad[{chunk, {LW{1'b0}}} +: W];
        rd1_addr = g_scan;
      end
      ST_L1: begin
        pe_in    = rd1;
        rd0_addr = w_l1;
      end
      ST_L0:    pe_in = rd0;
      ST_SREAD: pe_in = '0;
      ST_WB:    pe_in = '0;
      default:  pe_in = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (req_in)
            REQ_ALLOC:          state_next = ST_SCAN;
            REQ_FREE, REQ_MARK: state_next = in_range ? ST_SREAD : ST_WB;
            default:            state_next = ST_WB;
          endcase
        end
      end
      ST_SCAN: begin
        if (pe_any) state_next = ST_L1;
        else if (32'(chunk) == 32'(NC - 1)) state_next = ST_WB;
      end
      ST_L1:    state_next = ST_L0;
      ST_L0:    state_next = ST_WB;
      ST_SREAD: state_next = ST_WB;
      ST_WB:    if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  logic [ADDR_W-1:0] res_addr;
  logic              res_oom;
  logic [63:0]       addr_wide;

  assign addr_wide = 64'({w_r, pe_idx}) << PAGE_SHIFT;

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        chunk     <= '0;
        g_r       <= g_in;
        j_r       <= j_in;
        w_r       <= w_in;
        b_r       <= bit_in;
        is_free_r <= (req_in == REQ_FREE);
        write_r   <= 1'b0;
        res_addr  <= '0;
        res_oom   <= 1'b0;
      end
      ST_SCAN: begin
        chunk <= chunk + CW'(1);
        g_r   <= g_scan;
        // Only an empty last chunk means that no frame is free.
        if (!pe_any && 32'(chunk) == 32'(NC - 1)) res_oom <= 1'b1;
      end
      ST_L1: begin
        j_r      <= pe_idx;
        w_r      <= w_l1;
        l1word_r <= rd1;
      end
      ST_L0: begin
        new0_r   <= a_new0;
        new1_r   <= a_new1;
        write_r  <= 1'b1;
        res_addr <= addr_wide[ADDR_W-1:0];
      end
      ST_SREAD: begin
        new0_r  <= s_new0;
        new1_r  <= s_new1;
        write_r <= 1'b1;
      end
      ST_WB: begin
        chunk <= chunk;
      end
      default: begin
        chunk <= chunk;
      end
    endcase
  end

  // Bitmap memories.
  always_ff @(posedge clk) begin
    if (wb_fire && write_r) mem0[w_r] <= new0_r;
    rd0 <= mem0[rd0_addr];
  end

  always_ff @(posedge clk) begin
    if (wb_fire && write_r) mem1[g_r] <= new1_r;
    rd1 <= mem1[rd1_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l2 <= '0;
    end else if (wb_fire && write_r) begin
      l2[g_r] <= |new1_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (wb_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      m_tdata <= TDATA_W'(res_addr);
      m_tuser <= res_oom;
    end
  end

  // The summary bits promise a free frame below them, so the search cannot miss.
  a_search_hits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_L1 || state == ST_L0) |-> pe_any)
    else $error("summary bit set over an empty bitmap word");

  a_oom_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("out-of-memory result carries a nonzero address");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("new transaction accepted while one is in progress");

  a_summary_update: assert property (@(posedge clk) disable iff (rst)
    (wb_fire && write_r) |=> (l2[$past(g_r)] == $past(|new1_r)))
    else $error("top summary bit out of step with its level 1 word");

endmodule

[bench/tb_page_frame_bitmap_allocator.sv]
// Self-checking testbench for page_frame_bitmap_allocator: drives allocate, free, mark and
// unused requests on the input stream and checks each result against a local bitmap model.
// Depends on pfba_pkg and the allocator RTL.
module tb_page_frame_bitmap_allocator;
  import pfba_pkg::*;

  localparam int FPW         = FRAMES_PER_WORD_DEF;
  localparam int WORDS       = BITMAP_WORDS_DEF;
  localparam int PSHIFT      = PAGE_SHIFT_DEF;
  localparam int TOP_FRAME   = (1 << (ADDR_W - PSHIFT)) - 1;
  localparam int DRAIN_CYCLES = 16;

  // Request code that the package leaves unused.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              oom;
  } alloc_result_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata;  // [28:0] frame_address, [31:29] zero
  logic [REQ_W-1:0]   s_tuser;  // [1:0] req_type
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;  // [28:0] alloc_address, [31:29] zero
  logic [0:0]         m_tuser;  // [0] out_of_memory

  bit [FPW-1:0]  free_map [WORDS];
  alloc_result_t pending_results [$];
  int            errors;
  bit            src_idle;
  bit            sink_idle;
  int            hold_len;

  page_frame_bitmap_allocator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Applies one request to the local bitmap and returns the result it must produce.
  function automatic alloc_result_t apply_request(input logic [REQ_W-1:0] req,
                                                  input logic [ADDR_W-1:0] addr);
    alloc_result_t res;
    int frame;
    int word;
    res.addr = '0;
    res.oom  = 1'b0;
    frame = int'(addr >> PSHIFT);
    word  = frame / FPW;
    case (req)
      REQ_ALLOC: begin
        res.oom = 1'b1;
        for (int w = 0; w < WORDS && res.oom; w++) begin
          if (free_map[w] != '0) begin
            for (int b = 0; b < FPW && res.oom; b++) begin
              if (free_map[w][b]) begin
                free_map[w][b] = 1'b0;
                res.addr = ADDR_W'((longint'(w) * FPW + b) << PSHIFT);
                res.oom  = 1'b0;
              end
            end
          end
        end
      end
      REQ_FREE: if (word < WORDS) free_map[word][frame % FPW] = 1'b1;
      REQ_MARK: if (word < WORDS) free_map[word][frame % FPW] = 1'b0;
      default: ;
    endcase
    return res;
  endfunction

  // Leaves tvalid high after acceptance so back-to-back transactions need no idle gap.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr);
    int gap;
    if (src_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(TDATA_W-ADDR_W){1'b0}}, addr};
    s_tuser  <= req;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_request(req, addr));
  endtask

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] pick_frame_addr();
    logic [ADDR_W-PSHIFT-1:0] frame;
    logic [PSHIFT-1:0]        offs;
    offs = PSHIFT'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: frame = (ADDR_W-PSHIFT)'($urandom_range(0, 191));
      5, 6:          frame = (ADDR_W-PSHIFT)'($urandom_range(TOP_FRAME - 63, TOP_FRAME));
      default:       frame = (ADDR_W-PSHIFT)'($urandom);
    endcase
    return {frame, offs};
  endfunction

  task automatic test_after_reset();
    repeat (3) send_request(REQ_ALLOC, '0);
    send_request(REQ_UNUSED, '1);
    send_request(REQ_MARK, '0);
    send_request(REQ_ALLOC, '1);
    wait_results_done();
  endtask

  task automatic test_directed_cases();
    // Frame zero comes back as address zero without the out-of-memory flag.
    send_request(REQ_FREE, 29'h0000_0FFF);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_FREE, 29'h1FFF_FFFF);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_FREE, 29'h0002_1000);
    send_request(REQ_FREE, 29'h0000_1000);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_FREE, 29'h0000_1000);
    send_request(REQ_MARK, 29'h0000_1ABC);
    send_request(REQ_ALLOC, '0);
    // An unused code must leave the freed frame alone.
    send_request(REQ_FREE, 29'h0000_5000);
    send_request(REQ_UNUSED, 29'h0000_5000);
    send_request(REQ_ALLOC, '1);
    send_request(REQ_FREE, 29'h0001_F000);
    send_request(REQ_FREE, 29'h0002_0000);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_FREE, 29'h0000_7000);
    send_request(REQ_FREE, 29'h0000_7FFF);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, '0);
    wait_results_done();
  endtask

  task automatic test_output_stall();
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    hold_len  = 300;
    for (int i = 0; i < 20; i++) send_request(REQ_FREE, pick_frame_addr());
    for (int i = 0; i < 22; i++) send_request(REQ_ALLOC, pick_frame_addr());
    wait_results_done();
  endtask

  task automatic test_random_traffic();
    logic [ADDR_W-1:0] batch [$];
    int issued;
    int k;
    issued = 0;
    while (issued < 680) begin
      if (issued < 530) begin
        src_idle  = ($urandom_range(0, 4) != 0);
        sink_idle = ($urandom_range(0, 4) != 0);
      end else begin
        src_idle  = 1'b0;
        sink_idle = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          // Free a handful of frames, sometimes take one back, then allocate them again.
          batch.delete();
          k = $urandom_range(1, 8);
          for (int i = 0; i < k; i++) begin
            batch.push_back(pick_frame_addr());
            send_request(REQ_FREE, batch[i]);
          end
          if ($urandom_range(0, 2) == 0) begin
            send_request(REQ_MARK, batch[$urandom_range(0, k - 1)]);
            issued++;
          end
          k += $urandom_range(0, 1);
          for (int i = 0; i < k; i++) send_request(REQ_ALLOC, pick_frame_addr());
          issued += batch.size() + k;
        end
        7: begin
          k = $urandom_range(1, 3);
          for (int i = 0; i < k; i++) send_request(REQ_UNUSED, ADDR_W'($urandom));
          issued += k;
        end
        8: begin
          k = $urandom_range(1, 4);
          for (int i = 0; i < k; i++) begin
            send_request($urandom_range(0, 1) ? REQ_MARK : REQ_FREE, pick_frame_addr());
          end
          issued += k;
        end
        default: begin
          k = $urandom_range(1, 5);
          for (int i = 0; i < k; i++) send_request(REQ_ALLOC, ADDR_W'($urandom));
          issued += k;
        end
      endcase
    end
    wait_results_done();
  endtask

  // Result side: random stall bursts, plus a long hold-off when a test asks for one.
  initial begin : result_sink
    int stall;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_len > 0) begin
        m_tready <= 1'b0;
        repeat (hold_len - 1) @(posedge clk);
        hold_len = 0;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 18);
        m_tready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none outstanding: tdata=%h tuser=%b",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== {{(TDATA_W-ADDR_W){1'b0}}, want.addr}) begin
          $display("%0t: alloc_address expected %h actual %h", $time, want.addr, m_tdata);
          errors++;
        end
        if (m_tuser[0] !== want.oom) begin
          $display("%0t: out_of_memory expected %b actual %b", $time, want.oom, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("[page_frame_bitmap_allocator] ERROR");
    $finish;
  end

  initial begin
    errors    = 0;
    hold_len  = 0;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    foreach (free_map[i]) free_map[i] = '0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_after_reset();
    test_directed_cases();
    test_output_stall();
    test_random_traffic();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[page_frame_bitmap_allocator] OK");
    end else begin
      $display("[page_frame_bitmap_allocator] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/pfba_pkg.sv
rtl/page_frame_bitmap_allocator.sv
bench/tb_page_frame_bitmap_allocator.sv
